[src/ipal_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the IPv4 allowlist with expiry.
// Used by ipal_entry_ram, ipal_scan_unit and ip_allowlist_with_expiry_core.
package ipal_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int IP_W          = 32;
    localparam int TIME_W        = 32;
    localparam int EXPIRY_W      = TIME_W + 1;
    localparam int TAG_W         = 16;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Request kinds
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // One table slot as held in the entry memory
    typedef struct packed {
        logic [IP_W-1:0]     address;
        logic [EXPIRY_W-1:0] expiry;
        logic                has_tag;
        logic [TAG_W-1:0]    tag;
    } entry_t;

    // Outcome of one sweep over the table
    typedef struct packed {
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic             match_found;
        logic [IDX_W-1:0] match_idx;
        logic             match_has_tag;
        logic [TAG_W-1:0] match_tag;
    } scan_result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

endpackage

[src/ipal_entry_ram.sv]
`timescale 1ns / 1ps
// Entry memory: one write port, one registered read port, one slot per word.
// Depends on ipal_pkg for the slot layout and table depth.
module ipal_entry_ram
    import ipal_pkg::*;
(
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output entry_t           rd_data
);

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    // Write a slot
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    // Read a slot, data registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/ipal_scan_unit.sv]
`timescale 1ns / 1ps
// Shared compare unit: ages one slot a cycle and tracks match and free slot.
// Depends on ipal_pkg for the slot layout and the sweep result struct.
module ipal_scan_unit
    import ipal_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              eval_en,
    input  logic [IDX_W-1:0]  eval_idx,
    input  logic              live,
    input  entry_t            entry,
    input  logic [IP_W-1:0]   ip,
    input  logic [TIME_W-1:0] now,
    output logic              expire,
    output scan_result_t      result
);

    scan_result_t result_reg;
    scan_result_t result_next;
    logic         still_live;
    logic         addr_eq;

    // Compare expiry against now and address against the request
    always_comb begin
        expire     = eval_en && live && (entry.expiry <= {1'b0, now});
        still_live = live && !expire;
        addr_eq    = (entry.address == ip);
    end

    // Keep the first live match and the first free slot
    always_comb begin
        result_next = result_reg;
        if (start) begin
            result_next = '0;
        end else if (eval_en) begin
            if (still_live) begin
                if (!result_reg.match_found && addr_eq) begin
                    result_next.match_found   = 1'b1;
                    result_next.match_idx     = eval_idx;
                    result_next.match_has_tag = entry.has_tag;
                    result_next.match_tag     = entry.tag;
                end
            end else if (!result_reg.free_found) begin
                result_next.free_found = 1'b1;
                result_next.free_idx   = eval_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            result_reg <= '0;
        end else begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

[src/ip_allowlist_with_expiry_core.sv]
`timescale 1ns / 1ps
// IPv4 allowlist with per-slot expiry. Each item sweeps the table: one slot
// is read from the entry memory per cycle, aged and compared in a single
// compare unit, a drain state evaluates the last read, and the add or lookup
// is committed in a final commit state that loads the output register. A new
// item is taken only after the commit of the last one.
// The input is not ready during that sweep; a finished result waits in the
// output register while the next item is accepted and swept, and the commit
// holds until that register is free.
// Depends on ipal_pkg, ipal_entry_ram and ipal_scan_unit.
module ip_allowlist_with_expiry_core
    import ipal_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [IP_W-1:0]   s_client_ip,
    input  logic [TIME_W-1:0] s_ttl_seconds,
    input  logic [TIME_W-1:0] s_now_seconds,
    input  logic              s_has_domain,
    input  logic [TAG_W-1:0]  s_domain_tag,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_status,
    output logic              m_hit,
    output logic              m_tag_present,
    output logic [TAG_W-1:0]  m_found_tag
);

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0]       eval_idx_reg, eval_idx_next;
    logic [TABLE_ENTRIES-1:0] live_reg, live_next;

    // Captured request
    logic                   kind_reg;
    logic [IP_W-1:0]        ip_reg;
    logic [TIME_W-1:0]      ttl_reg;
    logic [TIME_W-1:0]      now_reg;
    logic                   has_domain_reg;
    logic [TAG_W-1:0]       tag_reg;

    // Output register
    logic                   m_valid_reg, m_valid_next;
    logic                   m_status_reg;
    logic                   m_hit_reg;
    logic                   m_tag_present_reg;
    logic [TAG_W-1:0]       m_found_tag_reg;

    logic                   accept;
    logic                   start;
    logic                   rd_en;
    logic                   commit_go;
    logic                   wr_en;
    logic                   insert_en;
    logic [IDX_W-1:0]       wr_idx;
    entry_t                 wr_data;
    entry_t                 rd_data;
    logic                   expire;
    scan_result_t           scan;
    logic [EXPIRY_W-1:0]    new_expiry;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign start   = accept;

    // Sequencer: sweep the table, then commit
    always_comb begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        eval_valid_next = 1'b0;
        eval_idx_next   = eval_idx_reg;
        rd_en           = 1'b0;
        commit_go       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    rd_idx_next = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_en           = 1'b1;
                eval_valid_next = 1'b1;
                eval_idx_next   = rd_idx_reg;
                if (rd_idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end else begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!m_valid_reg || m_ready) begin
                    commit_go  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            rd_idx_reg     <= '0;
            eval_valid_reg <= 1'b0;
            eval_idx_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            eval_valid_reg <= eval_valid_next;
            eval_idx_reg   <= eval_idx_next;
        end
    end

    // Hold the request for the whole sweep
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg       <= s_kind;
            ip_reg         <= s_client_ip;
            ttl_reg        <= s_ttl_seconds;
            now_reg        <= s_now_seconds;
            has_domain_reg <= s_has_domain;
            tag_reg        <= s_domain_tag;
        end
    end

    ipal_entry_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx_reg),
        .rd_data (rd_data)
    );

    ipal_scan_unit u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .eval_en  (eval_valid_reg),
        .eval_idx (eval_idx_reg),
        .live     (live_reg[eval_idx_reg]),
        .entry    (rd_data),
        .ip       (ip_reg),
        .now      (now_reg),
        .expire   (expire),
        .result   (scan)
    );

    // Build the slot write for a refresh or an insert
    always_comb begin
        new_expiry      = {1'b0, now_reg} + {1'b0, ttl_reg};
        wr_en           = commit_go && (kind_reg == KIND_ADD) && scan.free_found;
        insert_en       = wr_en && !scan.match_found;
        wr_data.address = ip_reg;
        wr_data.expiry  = new_expiry;
        if (scan.match_found) begin
            wr_idx          = scan.match_idx;
            wr_data.has_tag = has_domain_reg ? 1'b1 : scan.match_has_tag;
            wr_data.tag     = has_domain_reg ? tag_reg : scan.match_tag;
        end else begin
            wr_idx          = scan.free_idx;
            wr_data.has_tag = has_domain_reg;
            wr_data.tag     = has_domain_reg ? tag_reg : '0;
        end
    end

    // Drop expired slots during the sweep, mark inserted slots live
    always_comb begin
        live_next = live_reg;
        if (expire) begin
            live_next[eval_idx_reg] = 1'b0;
        end
        if (insert_en) begin
            live_next[scan.free_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= '0;
        end else begin
            live_reg <= live_next;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit_go) begin
            m_status_reg      <= (kind_reg == KIND_ADD) && !scan.free_found;
            m_hit_reg         <= (kind_reg == KIND_LOOKUP) && scan.match_found;
            m_tag_present_reg <= (kind_reg == KIND_LOOKUP) && scan.match_found
                                 && scan.match_has_tag;
            m_found_tag_reg   <= ((kind_reg == KIND_LOOKUP) && scan.match_found
                                  && scan.match_has_tag) ? scan.match_tag : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_hit         = m_hit_reg;
    assign m_tag_present = m_tag_present_reg;
    assign m_found_tag   = m_found_tag_reg;

    // An accepted item starts a sweep
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_SCAN))
        else $error("accepted item did not start a sweep");

    // A result only appears from a commit
    a_result_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_COMMIT))
        else $error("result raised outside commit");

    // An insert never overwrites a live slot
    a_insert_free: assert property (@(posedge aclk) disable iff (!aresetn)
        insert_en |-> !live_reg[scan.free_idx])
        else $error("insert into a live slot");

    // Commit never overwrites a waiting result
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        commit_go |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    // Slots only expire while a sweep is evaluating
    a_expire_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        expire |-> ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)))
        else $error("slot expired outside a sweep");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ip_allowlist_with_expiry_core: drives add and lookup
// items, predicts each result from its own table model, and checks them in order.
// Depends on ipal_pkg and the core RTL only.
module tb_top
    import ipal_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_500_000;

    typedef struct packed {
        logic             status;
        logic             hit;
        logic             tag_present;
        logic [TAG_W-1:0] found_tag;
    } allow_result_t;

    logic aclk = 1'b0;
    logic aresetn;

    logic              s_valid;
    logic              s_ready;
    logic              s_kind;
    logic [IP_W-1:0]   s_client_ip;
    logic [TIME_W-1:0] s_ttl_seconds;
    logic [TIME_W-1:0] s_now_seconds;
    logic              s_has_domain;
    logic [TAG_W-1:0]  s_domain_tag;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_status;
    logic              m_hit;
    logic              m_tag_present;
    logic [TAG_W-1:0]  m_found_tag;

    // Predicted allowlist contents
    logic                slot_live    [TABLE_ENTRIES];
    logic [IP_W-1:0]     slot_addr    [TABLE_ENTRIES];
    logic [EXPIRY_W-1:0] slot_expiry  [TABLE_ENTRIES];
    logic                slot_has_tag [TABLE_ENTRIES];
    logic [TAG_W-1:0]    slot_tag     [TABLE_ENTRIES];

    allow_result_t pending_results[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 30;
    int sink_idle_pct = 30;
    int sink_hold_req = 0;
    int sink_hold_left = 0;
    int sink_gap_left  = 0;

    ip_allowlist_with_expiry_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_client_ip   (s_client_ip),
        .s_ttl_seconds (s_ttl_seconds),
        .s_now_seconds (s_now_seconds),
        .s_has_domain  (s_has_domain),
        .s_domain_tag  (s_domain_tag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_hit         (m_hit),
        .m_tag_present (m_tag_present),
        .m_found_tag   (m_found_tag)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 80);
        return $urandom_range(1, 3);
    endfunction

    // Age the table at the item's time, then apply the add or lookup
    function automatic allow_result_t age_and_apply(
        input logic              kind,
        input logic [IP_W-1:0]   ip,
        input logic [TIME_W-1:0] ttl,
        input logic [TIME_W-1:0] now,
        input logic              with_tag,
        input logic [TAG_W-1:0]  tag
    );
        allow_result_t       res;
        logic [EXPIRY_W-1:0] now_ext;
        int                  used;
        int                  free_idx;
        int                  match_idx;
        res       = '0;
        now_ext   = {1'b0, now};
        used      = 0;
        free_idx  = -1;
        match_idx = -1;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (slot_live[k] && !(slot_expiry[k] > now_ext)) slot_live[k] = 1'b0;
        end
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (slot_live[k]) begin
                used++;
                if (match_idx < 0 && slot_addr[k] == ip) match_idx = k;
            end else if (free_idx < 0) begin
                free_idx = k;
            end
        end
        if (kind == KIND_ADD) begin
            if (used >= TABLE_ENTRIES || (match_idx < 0 && free_idx < 0)) begin
                res.status = 1'b1;
            end else if (match_idx >= 0) begin
                slot_expiry[match_idx] = now_ext + {1'b0, ttl};
                if (with_tag) begin
                    slot_has_tag[match_idx] = 1'b1;
                    slot_tag[match_idx]     = tag;
                end
            end else begin
                slot_addr[free_idx]    = ip;
                slot_expiry[free_idx]  = now_ext + {1'b0, ttl};
                slot_has_tag[free_idx] = with_tag;
                slot_tag[free_idx]     = with_tag ? tag : '0;
                slot_live[free_idx]    = 1'b1;
            end
        end else if (match_idx >= 0) begin
            res.hit = 1'b1;
            if (slot_has_tag[match_idx]) begin
                res.tag_present = 1'b1;
                res.found_tag   = slot_tag[match_idx];
            end
        end
        return res;
    endfunction

    // Offer one item, hold it until accepted, then queue its expected result
    task automatic send_item(
        input logic              kind,
        input logic [IP_W-1:0]   ip,
        input logic [TIME_W-1:0] ttl,
        input logic [TIME_W-1:0] now,
        input logic              with_tag,
        input logic [TAG_W-1:0]  tag
    );
        int gap;
        gap = pick_gap(src_idle_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_client_ip   <= ip;
        s_ttl_seconds <= ttl;
        s_now_seconds <= now;
        s_has_domain  <= with_tag;
        s_domain_tag  <= tag;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(age_and_apply(kind, ip, ttl, now, with_tag, tag));
    endtask

    task automatic add_ip(
        input logic [IP_W-1:0]   ip,
        input logic [TIME_W-1:0] ttl,
        input logic [TIME_W-1:0] now,
        input logic              with_tag,
        input logic [TAG_W-1:0]  tag
    );
        send_item(KIND_ADD, ip, ttl, now, with_tag, tag);
    endtask

    // Lookups carry random values in the fields the block ignores
    task automatic lookup_ip(input logic [IP_W-1:0] ip, input logic [TIME_W-1:0] now);
        send_item(KIND_LOOKUP, ip, TIME_W'($urandom), now, 1'($urandom_range(0, 1)),
                  TAG_W'($urandom));
    endtask

    // Compare one delivered item against the oldest expectation
    task automatic check_result();
        allow_result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("result delivered with nothing pending");
        end else begin
            want = pending_results.pop_front();
            if (m_status !== want.status)
                report_mismatch($sformatf("status got %b want %b", m_status, want.status));
            if (m_hit !== want.hit)
                report_mismatch($sformatf("hit got %b want %b", m_hit, want.hit));
            if (m_tag_present !== want.tag_present)
                report_mismatch($sformatf("tag_present got %b want %b",
                                          m_tag_present, want.tag_present));
            if (m_found_tag !== want.found_tag)
                report_mismatch($sformatf("found_tag got %h want %h",
                                          m_found_tag, want.found_tag));
        end
    endtask

    // Receiver: check items, then pace ready with gaps and requested hold-offs
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_result();
        if (sink_hold_req > 0) begin
            sink_hold_left = sink_hold_req;
            sink_hold_req  = 0;
        end
        if (sink_hold_left > 0) begin
            sink_hold_left--;
            m_ready <= 1'b0;
        end else if (sink_gap_left > 0) begin
            sink_gap_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            sink_gap_left = pick_gap(sink_idle_pct);
        end
    end

    // Insert, refresh with and without a tag, lookups that hit and miss
    task automatic test_add_lookup();
        lookup_ip(32'h0A00_0001, 32'd10);
        add_ip(32'h0A00_0001, 32'd100, 32'd10, 1'b1, 16'h1234);
        lookup_ip(32'h0A00_0001, 32'd10);
        add_ip(32'h0A00_0001, 32'd200, 32'd11, 1'b0, 16'hBEEF);
        lookup_ip(32'h0A00_0001, 32'd12);
        add_ip(32'h0A00_0001, 32'd200, 32'd12, 1'b1, 16'hFFFF);
        add_ip(32'h0000_0000, 32'd50, 32'd13, 1'b0, 16'hA5A5);
        lookup_ip(32'h0000_0000, 32'd13);
        add_ip(32'hFFFF_FFFF, 32'd300, 32'd14, 1'b1, 16'h0000);
        lookup_ip(32'hFFFF_FFFF, 32'd14);
        lookup_ip(32'h0A00_0001, 32'd15);
    endtask

    // Expiry equal to now frees the slot; time may also run backwards
    task automatic test_expiry_edges();
        add_ip(32'hC0A8_0001, 32'd0, 32'd500, 1'b1, 16'h0001);
        lookup_ip(32'hC0A8_0001, 32'd500);
        add_ip(32'hC0A8_0002, 32'd5, 32'd500, 1'b0, 16'h0000);
        lookup_ip(32'hC0A8_0002, 32'd504);
        lookup_ip(32'hC0A8_0002, 32'd505);
        lookup_ip(32'h0A00_0001, 32'd100);
    endtask

    // Expiry beyond 32 bits never wraps
    task automatic test_time_extremes();
        add_ip(32'h7F00_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'h8001);
        lookup_ip(32'h7F00_0001, 32'hFFFF_FFFF);
        lookup_ip(32'h7F00_0001, 32'h0000_0000);
        add_ip(32'h7F00_0001, 32'd0, 32'd0, 1'b0, 16'h7FFE);
        lookup_ip(32'h7F00_0001, 32'd0);
        add_ip(32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 1'b1, 16'h5A5A);
        lookup_ip(32'h8000_0000, 32'hFFFF_FFFF);
    endtask

    // Fill every slot, then adds are rejected even for a present address
    task automatic test_table_full();
        logic [IP_W-1:0] filled[TABLE_ENTRIES];
        logic [IP_W-1:0] stranger;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            filled[i] = {(IP_W-IDX_W)'($urandom), IDX_W'(i)};
            add_ip(filled[i], 32'd1000, 32'd1000, 1'($urandom_range(0, 1)), TAG_W'($urandom));
        end
        stranger = {(IP_W-IDX_W)'($urandom), IDX_W'(0)} ^ {1'b1, {(IP_W-1){1'b0}}};
        if (stranger == filled[0]) stranger = ~stranger;
        add_ip(filled[5], 32'd50, 32'd1001, 1'b1, 16'hCAFE);
        add_ip(stranger, 32'd50, 32'd1001, 1'b0, 16'h0000);
        lookup_ip(filled[5], 32'd1002);
        lookup_ip(filled[TABLE_ENTRIES-1], 32'd1999);
        lookup_ip(stranger, 32'd1999);
        add_ip(stranger, 32'd10, 32'd2000, 1'b1, 16'h0F0F);
        lookup_ip(filled[0], 32'd2000);
        lookup_ip(stranger, 32'd2001);
    endtask

    // Hold the receiver off long enough for the block to back up its input
    task automatic test_backpressure();
        src_idle_pct  = 0;
        sink_hold_req = 1200;
        for (int i = 0; i < 10; i++) begin
            if (i % 2 == 0)
                add_ip(32'h0101_0100 + i, 32'd100, 32'd5000 + i, 1'b1, TAG_W'(i));
            else
                lookup_ip(32'h0101_0100 + i - 1, 32'd5000 + i);
        end
    endtask

    // Episodes over a small address pool with a drifting clock
    task automatic test_random_traffic(input int n_items);
        logic [IP_W-1:0]   pool[$];
        logic [IP_W-1:0]   ip;
        logic [TIME_W-1:0] clock_now;
        logic [TIME_W-1:0] ttl;
        int                sent;
        int                pool_n;
        int                ttl_mode;
        int                ep_len;
        sent = 0;
        while (sent < n_items) begin
            pool.delete();
            pool_n = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 100)
                                                 : $urandom_range(2, 48);
            for (int i = 0; i < pool_n; i++) pool.push_back(IP_W'($urandom));
            if ($urandom_range(0, 3) == 0) pool[0] = '0;
            if ($urandom_range(0, 3) == 0) pool[pool_n-1] = '1;
            clock_now = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FF00 : TIME_W'($urandom);
            ttl_mode  = $urandom_range(0, 2);
            src_idle_pct  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            sink_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            ep_len = $urandom_range(40, 150);
            for (int i = 0; i < ep_len && sent < n_items; i++) begin
                // advance the clock, occasionally stepping back or jumping
                case ($urandom_range(0, 19))
                    0:       clock_now = clock_now - $urandom_range(1, 50);
                    1:       clock_now = clock_now + $urandom_range(50, 400);
                    default: clock_now = clock_now + $urandom_range(0, 3);
                endcase
                ip = ($urandom_range(0, 19) == 0) ? IP_W'($urandom)
                                                  : pool[$urandom_range(0, pool_n - 1)];
                case (ttl_mode)
                    0:       ttl = $urandom_range(0, 20);
                    1:       ttl = $urandom_range(0, 500);
                    default: ttl = TIME_W'($urandom);
                endcase
                if ($urandom_range(0, 9) < 4)
                    lookup_ip(ip, clock_now);
                else
                    add_ip(ip, ttl, clock_now, 1'($urandom_range(0, 1)), TAG_W'($urandom));
                sent++;
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_kind        = KIND_ADD;
        s_client_ip   = '0;
        s_ttl_seconds = '0;
        s_now_seconds = '0;
        s_has_domain  = 1'b0;
        s_domain_tag  = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) slot_live[k] = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_add_lookup();
        test_expiry_edges();
        test_time_extremes();
        test_table_full();
        test_backpressure();
        test_random_traffic(1400);

        // Drop valid, drain outstanding results, then allow the pipeline to settle
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TABLE_ENTRIES + 10) @(posedge aclk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
